// ----- rtl/serial_lcd_terminal_scroll_defines.svh -----
// Assertion macros shared by the terminal RTL.
`ifndef SERIAL_LCD_TERMINAL_SCROLL_DEFINES_SVH
`define SERIAL_LCD_TERMINAL_SCROLL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal assertion failed");

`endif

// ----- rtl/slt_pkg.sv -----
`default_nettype none
package slt_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 16;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_BACKLIGHT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic cmd_open;
    logic cmd_byte;
    logic cmd_close;
    logic emit_op;
    logic scroll_start;
    logic rd;
    logic emit_scroll;
    logic pad_start;
    logic emit_pad;
    logic lf_top;
    logic emit_char;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic cmd_mode;
    logic cmd_known;
    logic cur_full;
    logic cur_row1;
    logic col_last;
    logic slot_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/slt_datapath.sv -----
`default_nettype none
`include "serial_lcd_terminal_scroll_defines.svh"
module slt_datapath #(
  parameter int unsigned COLUMNS = slt_pkg::COLUMNS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        rx_char,
  input  wire slt_pkg::dp_cmd_t  cmd,
  output slt_pkg::dp_stat_t      stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             op,
  output logic                   row,
  output logic [3:0]             col,
  output logic [7:0]             glyph,
  output logic                   last
);
  import slt_pkg::*;

  localparam int unsigned CELLS = 2 * COLUMNS;
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned IW    = $clog2(COLUMNS);
  localparam int unsigned XW    = (IW > 4) ? IW : 4;
  localparam logic [CW-1:0] CUR_ROW1 = CW'(COLUMNS);
  localparam logic [CW-1:0] CUR_FULL = CW'(CELLS);
  localparam logic [IW-1:0] IDX_LAST = IW'(COLUMNS - 1);

  logic [7:0]    ch;
  logic [CW-1:0] cursor;
  logic          cmd_mode;
  logic [1:0]    cmd_len;
  logic [7:0]    cmd_first;
  logic [IW-1:0] idx;

  // Only the bottom row is ever read back, so only it is stored.
  logic [7:0]         mem [COLUMNS];
  logic [COLUMNS-1:0] vld;
  logic [7:0]         rd_data;
  logic               rd_valid;

  logic [CW-1:0] cur_off;
  logic          on_row1;
  logic [IW-1:0] cur_col;
  logic          is_clear;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cur_x;
  logic          any_emit;

  assign cur_off  = cursor - CUR_ROW1;
  assign on_row1  = cursor >= CUR_ROW1;
  assign cur_col  = on_row1 ? cur_off[IW-1:0] : cursor[IW-1:0];
  assign idx_x    = XW'(idx);
  assign cur_x    = XW'(cur_col);
  assign is_clear = cmd_first == CH_ZERO;

  assign mem_we = cmd.emit_pad || (cmd.emit_char && on_row1);
  assign mem_wa = cmd.emit_pad ? idx : cur_col;
  assign mem_wd = cmd.emit_pad ? CH_SPACE : ch;

  assign any_emit = cmd.emit_op || cmd.emit_scroll || cmd.emit_pad || cmd.emit_char;

  assign stat.is_cr     = ch == CH_CR;
  assign stat.is_lf     = ch == CH_LF;
  assign stat.cmd_mode  = cmd_mode;
  assign stat.cmd_known = (cmd_len == 2'd1) &&
                          (is_clear || cmd_first == CH_ONE || cmd_first == CH_TWO);
  assign stat.cur_full  = cursor >= CUR_FULL;
  assign stat.cur_row1  = on_row1;
  assign stat.col_last  = idx == IDX_LAST;
  assign stat.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      cmd_mode  <= 1'b0;
      cmd_len   <= 2'd0;
      cmd_first <= 8'd0;
      vld       <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (cmd.cmd_open) begin
        cmd_mode  <= 1'b1;
        cmd_len   <= 2'd0;
        cmd_first <= 8'd0;
      end
      if (cmd.cmd_byte) begin
        if (cmd_len == 2'd0) begin
          cmd_first <= ch;
        end
        if (cmd_len != 2'd2) begin
          cmd_len <= cmd_len + 2'd1;
        end
      end
      if (cmd.cmd_close) begin
        cmd_mode <= 1'b0;
        cmd_len  <= 2'd0;
        if (stat.cmd_known && is_clear) begin
          vld    <= '0;
          cursor <= '0;
        end
      end
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
      if (cmd.scroll_start) begin
        idx <= '0;
      end
      if (cmd.pad_start) begin
        idx <= cur_off[IW-1:0];
      end
      if (cmd.emit_scroll) begin
        if (idx == IDX_LAST) begin
          idx    <= '0;
          cursor <= CUR_ROW1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.emit_pad) begin
        idx <= idx + 1'b1;
        if (idx == IDX_LAST) begin
          cursor <= CUR_FULL;
        end
      end
      if (cmd.lf_top) begin
        cursor <= CUR_ROW1;
      end
      if (cmd.emit_char) begin
        cursor <= cursor + 1'b1;
      end
      if (any_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch <= rx_char;
    end
    if (cmd.emit_op) begin
      op    <= is_clear ? OP_CLEAR : OP_BACKLIGHT;
      row   <= 1'b0;
      col   <= 4'd0;
      glyph <= 8'd0;
      last  <= 1'b1;
    end
    if (cmd.emit_scroll) begin
      op    <= OP_WRITE;
      row   <= 1'b0;
      col   <= idx_x[3:0];
      glyph <= rd_valid ? rd_data : 8'd0;
      last  <= 1'b0;
    end
    if (cmd.emit_pad) begin
      op    <= OP_WRITE;
      row   <= 1'b1;
      col   <= idx_x[3:0];
      glyph <= CH_SPACE;
      last  <= idx == IDX_LAST;
    end
    if (cmd.emit_char) begin
      op    <= OP_WRITE;
      row   <= on_row1;
      col   <= cur_x[3:0];
      glyph <= ch;
      last  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      rd_data  <= mem[idx];
      rd_valid <= vld[idx];
    end
  end

  `SLT_ASSERT_IMPL(a_cursor_range, clk, rst, 1'b1, cursor <= CUR_FULL)
  `SLT_ASSERT_IMPL(a_emit_slot, clk, rst, any_emit, stat.slot_free)
  `SLT_ASSERT_IMPL(a_scroll_full, clk, rst, cmd.emit_scroll, cursor == CUR_FULL)

endmodule
`default_nettype wire

// ----- rtl/slt_ctrl.sv -----
`default_nettype none
`include "serial_lcd_terminal_scroll_defines.svh"
module slt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire slt_pkg::dp_stat_t stat,
  output slt_pkg::dp_cmd_t       cmd
);
  import slt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SC_RD,
    S_SC_OUT,
    S_PAD,
    S_CHAR,
    S_OPOUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.cmd_mode) begin
          if (stat.is_cr) begin
            if (stat.cmd_known) begin
              state_next = S_OPOUT;
            end else begin
              cmd.cmd_close = 1'b1;
              state_next    = S_IDLE;
            end
          end else begin
            cmd.cmd_byte = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.is_cr) begin
          cmd.cmd_open = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.cur_full) begin
          cmd.scroll_start = 1'b1;
          state_next       = S_SC_RD;
        end else if (stat.is_lf) begin
          if (stat.cur_row1) begin
            cmd.pad_start = 1'b1;
            state_next    = S_PAD;
          end else begin
            // A newline on the top row only moves the cursor down.
            cmd.lf_top = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_CHAR;
        end
      end
      S_SC_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SC_OUT;
      end
      S_SC_OUT: begin
        if (stat.slot_free) begin
          cmd.emit_scroll = 1'b1;
          if (stat.col_last) begin
            state_next = stat.is_lf ? S_PAD : S_CHAR;
          end else begin
            state_next = S_SC_RD;
          end
        end
      end
      S_PAD: begin
        if (stat.slot_free) begin
          cmd.emit_pad = 1'b1;
          if (stat.col_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CHAR: begin
        if (stat.slot_free) begin
          cmd.emit_char = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_OPOUT: begin
        if (stat.slot_free) begin
          cmd.emit_op   = 1'b1;
          cmd.cmd_close = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SLT_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

// ----- rtl/serial_lcd_terminal_scroll.sv -----
`default_nettype none
// Serial terminal for a two-row character display of COLUMNS columns. Each
// received byte beat on rx_char turns into zero or more display operations on
// the result channel, the final one of each byte marked by last. A byte that
// gives no result (command text, a carriage return, a newline on the top row)
// is captured and decided; a plain character then adds a step that emits it.
// A byte that scrolls reads the bottom row back from its store column by
// column, a read and then an emit for each. Each emit waits for a free output
// slot. The store needs no clearing pass after reset: per-entry valid bits
// make unwritten cells read as zero.
module serial_lcd_terminal_scroll #(
  parameter int unsigned COLUMNS = slt_pkg::COLUMNS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      op,
  output logic            row,
  output logic [3:0]      col,
  output logic [7:0]      glyph,
  output logic            last
);
  import slt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slt_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_char   (rx_char),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .op        (op),
    .row       (row),
    .col       (col),
    .glyph     (glyph),
    .last      (last)
  );

endmodule
`default_nettype wire
